// ===== sv/rde_pkg.sv =====
`timescale 1ns / 1ps
// rde_pkg: beat types, operation and result codes for the reversible deque engine
// no dependencies; imported by rde_outq and reversible_deque_engine_unit

package rde_pkg;

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_REVERSE = 2'd1;
	localparam logic [1:0] OP_DELETE  = 2'd2;
	localparam logic [1:0] OP_FINISH  = 2'd3;

	localparam logic [1:0] KIND_ELEMENT  = 2'd0;
	localparam logic [1:0] KIND_EMPTY    = 2'd1;
	localparam logic [1:0] KIND_ERROR    = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] value;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] element;
		logic        last;
	} rsp_beat_t;

	// push request into the output queue
	typedef struct packed {
		logic      valid;
		rsp_beat_t beat;
	} outq_push_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage

// ===== sv/rde_mem.sv =====
`timescale 1ns / 1ps
// rde_mem: element storage, one write port and one read port, registered read data
// depends on: nothing beyond its parameter

module rde_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/rde_outq.sv =====
`timescale 1ns / 1ps
// rde_outq: two-entry result queue that decouples the engine from the receiver
// depends on: rde_pkg

module rde_outq
	import rde_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  outq_push_t push,
	output logic [1:0] level,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_beat_t  rsp
);

	rsp_beat_t ent_q [2];
	logic      wp_q;
	logic      rp_q;
	logic [1:0] level_q;
	logic      pop;

	assign pop       = rsp_valid & rsp_ready;
	assign rsp_valid = (level_q != 2'd0);
	assign rsp       = ent_q[rp_q];
	assign level     = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
			level_q <= 2'd0;
		end else begin
			if (push.valid) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			level_q <= level_q + {1'b0, push.valid} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			ent_q[wp_q] <= push.beat;
		end
	end

	// no push into a full queue unless an entry leaves in the same cycle
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && level_q == 2'd2) |-> pop)
		else $error("result queue overflow");

	// level only moves by the push and pop of the previous cycle
	a_level_track: assert property (@(posedge clk) disable iff (!arst_n)
		(!push.valid && !pop) |=> $stable(level_q))
		else $error("result queue level changed without a beat");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q != 2'd3)
		else $error("result queue level out of range");

endmodule

// ===== sv/reversible_deque_engine_unit.sv =====
`timescale 1ns / 1ps
// reversible_deque_engine_unit: bounded deque with a logical reverse flag, top level
// depends on: rde_pkg, rde_mem, rde_outq
//
// usage
// - req channel (req_valid / req_ready / req) carries one command beat: load, reverse,
//   delete front or finish. load, reverse and delete are taken one per cycle while no
//   drain runs and give no result beat.
// - rsp channel (rsp_valid / rsp_ready / rsp) carries result beats. a finish gives one
//   beat (delete error, overflow or empty list) or one beat per stored element in
//   logical order, last set on the final one.
// - a single-beat finish is pushed into the output queue in the cycle it is taken. an
//   element drain starts once the finish has put the engine in its drain state, reads
//   the element memory one entry per cycle while the output queue has room, and each
//   beat passes through the registered read data and then the output queue. the read
//   port of the element memory sets that rate.
// - no command is taken while a drain runs; loads, reverses and deletes are otherwise
//   taken even while result beats wait in the two-entry output queue. a finish waits
//   until the queue has room.
// - when the receiver stalls, the drain stops issuing reads once the output queue and
//   the read in flight would fill it, and resumes as beats leave.
// - reset clears head, count and all flags; element memory content is left as is and is
//   only read inside the occupied window. a finish clears the same state.

module reversible_deque_engine_unit
	import rde_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_beat_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	// control state
	state_t         state_q;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  occ_q;
	logic           rev_q;
	logic           err_q;
	logic           ovf_q;
	logic [CW-1:0]  k_q;

	// read pipeline
	logic           rd_s1;
	logic           last_s1;

	logic           accept;
	logic           full;
	logic           single;
	logic [1:0]     single_kind;
	logic [1:0]     level;
	logic           pop;
	logic           rd_issue;
	logic           drain_last;
	logic [CW-1:0]  off;
	logic [SW-1:0]  tail_sum;
	logic [SW-1:0]  rd_sum;
	logic [AW-1:0]  tail_addr;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  head_inc;
	logic           we;
	logic [15:0]    rdata;
	outq_push_t     push;

	assign accept = req_valid & req_ready;
	assign full   = (occ_q == CW'(DEPTH));
	assign pop    = rsp_valid & rsp_ready;

	// a finish that answers with one beat: flag set or empty store
	assign single      = err_q | ovf_q | (occ_q == '0);
	assign single_kind = err_q ? KIND_ERROR : (ovf_q ? KIND_OVERFLOW : KIND_EMPTY);

	// finish needs a free queue slot and no element beat landing in the same cycle
	assign req_ready = (state_q == ST_IDLE) &&
		((req.operation != OP_FINISH) || (!rd_s1 && level != 2'd2));

	// physical tail: head plus count, wrapped once
	always_comb begin
		tail_sum = SW'(head_q) + SW'(occ_q);
		if (tail_sum >= SW'(DEPTH)) begin
			tail_sum = tail_sum - SW'(DEPTH);
		end
		tail_addr = tail_sum[AW-1:0];
	end

	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	// drain read address in logical order
	always_comb begin
		off = rev_q ? (occ_q - CW'(1) - k_q) : k_q;
		rd_sum = SW'(head_q) + SW'(off);
		if (rd_sum >= SW'(DEPTH)) begin
			rd_sum = rd_sum - SW'(DEPTH);
		end
		rd_addr = rd_sum[AW-1:0];
	end

	// issue a read only when its beat is sure to find a queue slot
	assign rd_issue = (state_q == ST_DRAIN) &&
		(({1'b0, level} + {2'b00, rd_s1}) < (3'd2 + {2'b00, pop}));
	assign drain_last = (k_q == occ_q - CW'(1));

	assign we = accept && (req.operation == OP_LOAD) && !err_q && !full;

	rde_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (tail_addr),
		.wdata (req.value),
		.re    (rd_issue),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// element beats from the read pipe and single beats from a finish never coincide
	always_comb begin
		push.valid = rd_s1 || (accept && (req.operation == OP_FINISH) && single);
		if (rd_s1) begin
			push.beat = '{kind: KIND_ELEMENT, element: rdata, last: last_s1};
		end else begin
			push.beat = '{kind: single_kind, element: 16'd0, last: 1'b1};
		end
	end

	rde_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.level     (level),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
			rev_q   <= 1'b0;
			err_q   <= 1'b0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
			rd_s1   <= 1'b0;
		end else begin
			rd_s1 <= rd_issue;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.operation)
							OP_LOAD: begin
								if (!err_q) begin
									if (full) begin
										ovf_q <= 1'b1;
									end else begin
										occ_q <= occ_q + CW'(1);
									end
								end
							end
							OP_REVERSE: begin
								if (!err_q) begin
									rev_q <= ~rev_q;
								end
							end
							OP_DELETE: begin
								if (!err_q) begin
									if (occ_q == '0) begin
										err_q <= 1'b1;
									end else begin
										if (!rev_q) begin
											head_q <= head_inc;
										end
										occ_q <= occ_q - CW'(1);
									end
								end
							end
							default: begin
								// finish
								if (single) begin
									head_q <= '0;
									occ_q  <= '0;
									rev_q  <= 1'b0;
									err_q  <= 1'b0;
									ovf_q  <= 1'b0;
								end else begin
									k_q     <= '0;
									state_q <= ST_DRAIN;
								end
							end
						endcase
					end
				end
				ST_DRAIN: begin
					if (rd_issue) begin
						k_q <= k_q + CW'(1);
						if (drain_last) begin
							head_q  <= '0;
							occ_q   <= '0;
							rev_q   <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= drain_last;
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	// element read data only arrives for reads issued while draining
	a_rd_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> $past(state_q == ST_DRAIN))
		else $error("read issued outside a drain");

	// a finish leaves the sticky flags cleared
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == OP_FINISH) |=> (!err_q && !ovf_q))
		else $error("flags survive a finish");

	// no load or delete lands while elements are being drained
	a_drain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !we)
		else $error("store written during drain");

endmodule
